// ===== design/rccd_pkg.sv =====
package rccd_pkg;

   localparam int unsigned RATIO_W  = 16;
   localparam int unsigned TICK_W   = 32;
   localparam int unsigned RESULT_W = 48;
   localparam int unsigned TOTAL_W  = 64;
   localparam int unsigned PROD_W   = TICK_W + RATIO_W;
   localparam int unsigned DIVD_W   = PROD_W + 1;
   localparam int unsigned DIV_STEPS = DIVD_W;
   localparam int unsigned CNT_W    = $clog2(DIV_STEPS);
   localparam int unsigned CSR_IDX_W = 2;

   // request codes
   localparam logic [1:0] REQ_ADVANCE = 2'd0;
   localparam logic [1:0] REQ_QUERY   = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUMERATOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DENOMINATOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PHASE = 2'd2;

   // register reset values
   localparam logic [RATIO_W-1:0] NUM_RESET   = 16'd1;
   localparam logic [RATIO_W-1:0] DEN_RESET   = 16'd1;
   localparam logic [RATIO_W-1:0] PHASE_RESET = 16'd0;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [TICK_W-1:0] tick_count;
   } req_data_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result_ticks;
      logic [TOTAL_W-1:0]  delivered_total;
      logic [RATIO_W-1:0]  phase_now;
      logic                status;
   } rsp_data_type;

   typedef struct packed {
      logic               ok;
      logic [RATIO_W-1:0] num;
      logic [RATIO_W-1:0] den;
      logic [RATIO_W-1:0] phase;
   } cfg_eff_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic prep;
      logic step;
      logic finish;
      logic cfg_we;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } sts_type;

   // all-zero registers mean 1:1; other zero ratios or a phase at or past the
   // denominator are invalid
   function automatic cfg_eff_type resolve_cfg(input logic [RATIO_W-1:0] num,
                                                input logic [RATIO_W-1:0] den,
                                                input logic [RATIO_W-1:0] sp);
      cfg_eff_type r;
      if (num == '0 && den == '0 && sp == '0) begin
         r.ok    = 1'b1;
         r.num   = RATIO_W'(1);
         r.den   = RATIO_W'(1);
         r.phase = '0;
      end else if (num != '0 && den != '0 && sp < den) begin
         r.ok    = 1'b1;
         r.num   = num;
         r.den   = den;
         r.phase = sp;
      end else begin
         r.ok    = 1'b0;
         r.num   = '0;
         r.den   = '0;
         r.phase = '0;
      end
      return r;
   endfunction

endpackage

// ===== design/rccd_ctrl.sv =====
module rccd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  rccd_pkg::sts_type sts,
   output rccd_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_PREP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      idle;
   logic      out_free;

   assign idle      = (state_ff == ST_IDLE);
   assign req_stall = !idle;
   assign csr_ready = idle;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.capture = idle && req_valid;
      cmd.mul     = (state_ff == ST_MUL);
      cmd.prep    = (state_ff == ST_PREP);
      cmd.step    = (state_ff == ST_DIV);
      cmd.finish  = (state_ff == ST_FIN) && out_free;
      cmd.cfg_we  = idle && csr_valid;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_PREP;
         ST_PREP: state_in = sts.need_div ? ST_DIV : ST_FIN;
         ST_DIV: begin
            if (sts.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/rccd_dp.sv =====
module rccd_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rccd_pkg::cmd_type                      cmd,
   output rccd_pkg::sts_type                      sts,
   input  rccd_pkg::req_data_type                 req_data,
   output rccd_pkg::rsp_data_type                 rsp_data,
   input  logic [rccd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rccd_pkg::RATIO_W-1:0]           csr_wdata
);

   localparam int unsigned RW = rccd_pkg::RATIO_W;
   localparam int unsigned TW = rccd_pkg::TICK_W;
   localparam int unsigned PW = rccd_pkg::PROD_W;
   localparam int unsigned DW = rccd_pkg::DIVD_W;
   localparam int unsigned OW = rccd_pkg::RESULT_W;
   localparam int unsigned SW = rccd_pkg::TOTAL_W;
   localparam int unsigned CW = rccd_pkg::CNT_W;

   // configuration
   logic [RW-1:0] num_ff, num_in;
   logic [RW-1:0] den_ff, den_in;
   logic [RW-1:0] sp_ff, sp_in;
   logic          cfg_hit;
   rccd_pkg::cfg_eff_type eff, eff_new;

   // converter state
   logic [RW-1:0] phase_ff, phase_in;
   logic [SW-1:0] total_ff, total_in;

   // item in flight
   logic [1:0]    op_ff;
   logic [TW-1:0] tick_ff;
   logic [PW-1:0] prod_ff;
   logic [DW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          div_adv_ff, div_qry_ff, one_ff, status_ff, restart_ff;
   rccd_pkg::rsp_data_type rsp_ff;

   logic          is_adv, is_qry, is_rst;
   logic          above, adv_div, qry_div, err;
   logic [RW-1:0] mul_op;
   logic [DW-1:0] dividend;
   logic [RW:0]   rem_sh;
   logic          q_bit;
   logic [OW-1:0] quo_res, result;
   logic [RW-1:0] phase_next;
   logic [SW-1:0] total_next;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      sp_in  = sp_ff;
      cfg_hit = 1'b0;
      if (cmd.cfg_we) begin
         unique case (csr_index)
            rccd_pkg::CSR_NUMERATOR: begin
               num_in  = csr_wdata;
               cfg_hit = 1'b1;
            end
            rccd_pkg::CSR_DENOMINATOR: begin
               den_in  = csr_wdata;
               cfg_hit = 1'b1;
            end
            rccd_pkg::CSR_START_PHASE: begin
               sp_in   = csr_wdata;
               cfg_hit = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign eff     = rccd_pkg::resolve_cfg(num_ff, den_ff, sp_ff);
   assign eff_new = rccd_pkg::resolve_cfg(num_in, den_in, sp_in);

   // request classification, used in the multiply and prep cycles
   assign is_adv  = (op_ff == rccd_pkg::REQ_ADVANCE);
   assign is_qry  = (op_ff == rccd_pkg::REQ_QUERY);
   assign is_rst  = (op_ff == rccd_pkg::REQ_RESTART);
   assign above   = prod_ff > PW'(phase_ff);
   assign adv_div = is_adv && eff.ok;
   assign qry_div = is_qry && eff.ok && (tick_ff != '0) && above;
   assign err     = (is_adv && !eff.ok) ||
                    (is_qry && (!eff.ok || tick_ff == '0)) ||
                    (is_rst && !eff.ok);
   assign mul_op  = is_qry ? eff.den : eff.num;

   // advance: floor((t*num + phase) / den), remainder is the new phase
   // query: ceil((t*den - phase) / num) as floor((t*den - phase - 1) / num) + 1
   always_comb begin
      if (is_adv) begin
         dividend = {1'b0, prod_ff} + DW'(phase_ff);
      end else begin
         dividend = {1'b0, prod_ff - PW'(phase_ff) - PW'(1)};
      end
   end

   assign sts.need_div = adv_div || qry_div;
   assign sts.div_last = (cnt_ff == CW'(rccd_pkg::DIV_STEPS - 1));

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[DW-1]};
   assign q_bit  = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.prep) begin
         quo_in = dividend;
         rem_in = '0;
      end else if (cmd.step) begin
         quo_in = {quo_ff[DW-2:0], q_bit};
         rem_in = q_bit ? RW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[RW-1:0];
      end
   end

   // the quotient never exceeds the result width
   assign quo_res = quo_ff[OW-1:0];

   always_comb begin
      if (div_adv_ff) begin
         result = quo_res;
      end else if (div_qry_ff) begin
         result = quo_res + OW'(1);
      end else if (one_ff) begin
         result = OW'(1);
      end else begin
         result = '0;
      end
   end

   always_comb begin
      if (restart_ff) begin
         phase_next = eff.phase;
         total_next = '0;
      end else if (div_adv_ff) begin
         phase_next = rem_ff;
         total_next = total_ff + SW'(quo_res);
      end else begin
         phase_next = phase_ff;
         total_next = total_ff;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      total_in = total_ff;
      priority if (cfg_hit) begin
         phase_in = eff_new.phase;
         total_in = '0;
      end else if (cmd.finish) begin
         phase_in = phase_next;
         total_in = total_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= rccd_pkg::NUM_RESET;
         den_ff   <= rccd_pkg::DEN_RESET;
         sp_ff    <= rccd_pkg::PHASE_RESET;
         phase_ff <= '0;
         total_ff <= '0;
      end else begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         sp_ff    <= sp_in;
         phase_ff <= phase_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_data.req_type;
         tick_ff <= req_data.tick_count;
      end
      if (cmd.mul) begin
         prod_ff <= PW'(tick_ff) * PW'(mul_op);
      end
      if (cmd.prep) begin
         dsr_ff     <= is_adv ? eff.den : eff.num;
         div_adv_ff <= adv_div;
         div_qry_ff <= qry_div;
         one_ff     <= is_qry && eff.ok && (tick_ff != '0) && !above;
         status_ff  <= err;
         restart_ff <= is_rst;
         cnt_ff     <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.finish) begin
         rsp_ff.result_ticks    <= result;
         rsp_ff.delivered_total <= total_next;
         rsp_ff.phase_now       <= phase_next;
         rsp_ff.status          <= status_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/rational_clock_domain_converter_core.sv =====
// Rational clock ratio converter.
// req_* channel (valid/stall): one item per request; req_type selects
// advance, query or restart, tick_count carries elapsed or target ticks.
// rsp_* channel (valid/stall): exactly one result item per request, in order.
// csr_* channel (valid/ready): writes numerator, denominator or start phase
// by index; a write to one of these restarts the converter (phase reloaded, total cleared).
// csr_ready is high only while no request is in work.
// Advance and valid non-trivial query pass from accept to rsp_valid through
// multiply, setup, the 49-step restoring divider and finish; other requests
// skip the divider. One item is in work at a time, so a new request waits
// until the last one is finished. The 49-bit divider loop sets the rate.
// The finished result sits in an output register, so a new item is accepted
// while that result waits; the next result then waits in its finish state
// until rsp_stall drops.
// Reset: ratio 1:1, start phase 0, total 0, no result pending.
module rational_clock_domain_converter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rccd_pkg::req_data_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rccd_pkg::rsp_data_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rccd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rccd_pkg::RATIO_W-1:0]        csr_wdata
);

   rccd_pkg::cmd_type cmd;
   rccd_pkg::sts_type sts;

   rccd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rccd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== test/rational_clock_domain_converter_core_tb.sv =====
`timescale 1ns / 1ps

module rational_clock_domain_converter_core_tb;

   localparam int unsigned RATIO_W   = rccd_pkg::RATIO_W;
   localparam int unsigned TICK_W    = rccd_pkg::TICK_W;
   localparam int unsigned RESULT_W  = rccd_pkg::RESULT_W;
   localparam int unsigned TOTAL_W   = rccd_pkg::TOTAL_W;
   localparam int unsigned CSR_IDX_W = rccd_pkg::CSR_IDX_W;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rccd_pkg::req_data_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rccd_pkg::rsp_data_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = rccd_pkg::CSR_NUMERATOR;
   logic [RATIO_W-1:0]     csr_wdata = '0;

   rational_clock_domain_converter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   rccd_pkg::req_data_type pending_requests[$];
   rccd_pkg::rsp_data_type expected_results[$];
   int unsigned  error_count = 0;
   bit           no_idle = 1'b0;

   // converter state as the block should hold it
   logic [RATIO_W-1:0] reg_num = rccd_pkg::NUM_RESET;
   logic [RATIO_W-1:0] reg_den = rccd_pkg::DEN_RESET;
   logic [RATIO_W-1:0] reg_phase = rccd_pkg::PHASE_RESET;
   logic               ratio_ok;
   logic [RATIO_W-1:0] ratio_num;
   logic [RATIO_W-1:0] ratio_den;
   logic [RATIO_W-1:0] phase_load;
   logic [RATIO_W-1:0] phase_rem;
   logic [TOTAL_W-1:0] total_ticks;

   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(0, 17);
   endfunction

   // all-zero registers fall back to 1:1; other zero ratios or a phase at or
   // past the denominator leave the converter invalid
   function automatic void reload_converter();
      if (reg_num == 0 && reg_den == 0 && reg_phase == 0) begin
         ratio_ok   = 1'b1;
         ratio_num  = RATIO_W'(1);
         ratio_den  = RATIO_W'(1);
         phase_load = '0;
      end else if (reg_num != 0 && reg_den != 0 && reg_phase < reg_den) begin
         ratio_ok   = 1'b1;
         ratio_num  = reg_num;
         ratio_den  = reg_den;
         phase_load = reg_phase;
      end else begin
         ratio_ok   = 1'b0;
         ratio_num  = '0;
         ratio_den  = '0;
         phase_load = '0;
      end
      phase_rem   = phase_load;
      total_ticks = '0;
   endfunction

   function automatic rccd_pkg::rsp_data_type convert_request(
      input rccd_pkg::req_data_type r);
      rccd_pkg::rsp_data_type o;
      logic [63:0]  ticks;
      logic [63:0]  acc;
      logic [63:0]  need;
      logic [63:0]  res;
      o     = '0;
      res   = '0;
      ticks = 64'(r.tick_count);
      unique case (r.req_type)
         rccd_pkg::REQ_ADVANCE: begin
            if (!ratio_ok) begin
               o.status = 1'b1;
            end else if (ratio_num == ratio_den) begin
               // equal ratio: phase frozen
               res = ticks;
               total_ticks += ticks;
            end else begin
               acc = (ticks % 64'(ratio_den)) * 64'(ratio_num) + 64'(phase_rem);
               res = (ticks / 64'(ratio_den)) * 64'(ratio_num) + acc / 64'(ratio_den);
               phase_rem = RATIO_W'(acc % 64'(ratio_den));
               total_ticks += res;
            end
         end
         rccd_pkg::REQ_QUERY: begin
            if (!ratio_ok || ticks == 0) begin
               o.status = 1'b1;
            end else begin
               need = ticks * 64'(ratio_den);
               if (need <= 64'(phase_rem)) begin
                  res = 64'd1;
               end else begin
                  // round up: fewest source ticks reaching the target
                  need = need - 64'(phase_rem);
                  res  = need / 64'(ratio_num);
                  if (need % 64'(ratio_num) != 0) res = res + 64'd1;
               end
            end
         end
         rccd_pkg::REQ_RESTART: begin
            reload_converter();
            o.status = !ratio_ok;
         end
         default: ;
      endcase
      o.result_ticks    = res[RESULT_W-1:0];
      o.delivered_total = total_ticks;
      o.phase_now       = phase_rem;
      return o;
   endfunction

   task automatic check_result(input rccd_pkg::rsp_data_type got);
      rccd_pkg::rsp_data_type want;
      if (expected_results.size() == 0) begin
         $error("result item with nothing expected");
         error_count++;
         return;
      end
      want = expected_results.pop_front();
      if (got.result_ticks !== want.result_ticks) begin
         $error("result_ticks expected %0d actual %0d", want.result_ticks, got.result_ticks);
         error_count++;
      end
      if (got.delivered_total !== want.delivered_total) begin
         $error("delivered_total expected %0d actual %0d",
                want.delivered_total, got.delivered_total);
         error_count++;
      end
      if (got.phase_now !== want.phase_now) begin
         $error("phase_now expected %0d actual %0d", want.phase_now, got.phase_now);
         error_count++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         error_count++;
      end
   endtask

   // request driver
   int unsigned req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(convert_request(req_data));
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending_requests.size() != 0) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
               req_gap   <= draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor; after each taken result a random stall is drawn and held while valid counts it down
   int unsigned rsp_wait = 0;
   int unsigned rsp_draw;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         check_result(rsp_data);
         rsp_draw = draw_wait();
         rsp_wait  <= rsp_draw;
         rsp_stall <= (rsp_draw != 0);
      end else if (rsp_wait != 0 && rsp_valid) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= (rsp_wait != 1);
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATIO_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      unique case (idx)
         rccd_pkg::CSR_NUMERATOR:   reg_num = val;
         rccd_pkg::CSR_DENOMINATOR: reg_den = val;
         default:                   reg_phase = val;
      endcase
      reload_converter();
   endtask

   task automatic apply_ratio(input logic [RATIO_W-1:0] num, input logic [RATIO_W-1:0] den,
                              input logic [RATIO_W-1:0] sp);
      wait_drained();
      write_reg(rccd_pkg::CSR_NUMERATOR, num);
      write_reg(rccd_pkg::CSR_DENOMINATOR, den);
      write_reg(rccd_pkg::CSR_START_PHASE, sp);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned        pick;
      logic [1:0]         kind;
      logic [TICK_W-1:0]  ticks;
      logic [RATIO_W-1:0] num;
      logic [RATIO_W-1:0] den;
      logic [RATIO_W-1:0] sp;

      reload_converter();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset ratio is 1:1
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'd0});
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'd0});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'hFFFF_FFFF});
      pending_requests.push_back({2'd3, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_RESTART, 32'h5A5A_5A5A});

      apply_ratio(16'd3, 16'd7, 16'd5);
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'd1});
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'd1});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'd0});
      pending_requests.push_back({rccd_pkg::REQ_RESTART, 32'd0});

      apply_ratio(16'd0, 16'd5, 16'd0);
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'd9});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'd9});
      pending_requests.push_back({rccd_pkg::REQ_RESTART, 32'd0});

      apply_ratio(16'd0, 16'd0, 16'd0);
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'd10});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'd3});

      apply_ratio(16'hFFFF, 16'd1, 16'd0);
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'hFFFF_FFFF});

      apply_ratio(16'd1, 16'hFFFF, 16'hFFFE);
      pending_requests.push_back({rccd_pkg::REQ_ADVANCE, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'hFFFF_FFFF});
      pending_requests.push_back({rccd_pkg::REQ_QUERY, 32'd1});

      for (int phase_idx = 0; phase_idx < 14; phase_idx++) begin
         unique case (phase_idx)
            0:  apply_ratio(16'd0, 16'd0, 16'd0);
            1:  apply_ratio(16'hFFFF, 16'd1, 16'd0);
            2:  apply_ratio(16'd1, 16'hFFFF, 16'hFFFE);
            3:  apply_ratio(16'd0, 16'd5, 16'd0);
            4:  apply_ratio(16'd7, 16'd7, 16'd3);
            5:  apply_ratio(16'd10, 16'd3, 16'd3);
            6:  apply_ratio(16'hFFFF, 16'hFFFE, 16'hFFFD);
            7:  apply_ratio(16'd5, 16'd0, 16'd0);
            default: begin
               num = RATIO_W'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 20)
                                                          : $urandom_range(1, 65535));
               den = RATIO_W'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 20)
                                                          : $urandom_range(1, 65535));
               sp  = RATIO_W'($urandom_range(0, den - 1));
               apply_ratio(num, den, sp);
            end
         endcase
         no_idle = (phase_idx % 4 == 3);
         repeat (50) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)      kind = rccd_pkg::REQ_ADVANCE;
            else if (pick < 8) kind = rccd_pkg::REQ_QUERY;
            else if (pick < 9) kind = rccd_pkg::REQ_RESTART;
            else               kind = 2'd3;
            pick = $urandom_range(0, 9);
            if (pick < 4)       ticks = $urandom_range(0, 40);
            else if (pick < 8)  ticks = $urandom;
            else if (pick == 8) ticks = 32'hFFFF_FFFF - $urandom_range(0, 3);
            else                ticks = 32'd1 << $urandom_range(0, 31);
            pending_requests.push_back({kind, ticks});
         end
      end
      no_idle = 1'b0;

      wait_drained();
      if (error_count == 0) begin
         $display("[rational_clock_domain_converter_core] OK");
      end else begin
         $display("[rational_clock_domain_converter_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[rational_clock_domain_converter_core] ERROR");
      $finish;
   end

endmodule
